// File: src/eps_pkg.sv
// Shared widths, codes and control types of the epipolar pair scorer.
package eps_pkg;

   localparam int COEF_W   = 48;
   localparam int PT_W     = 24;
   localparam int SCORE_W  = 24;
   localparam int TOTAL_W  = 40;
   localparam int L_W      = 75;
   localparam int U_W      = 101;
   localparam int A_W      = 101;
   localparam int DIG_W    = 8;
   localparam int NDIG_MAX = 13;
   localparam int B_W      = DIG_W * NDIG_MAX;
   localparam int ACC_W    = 226;
   localparam int QUOT_W   = 24;
   localparam int CNT_W    = 4;
   localparam int DCNT_W   = 5;
   localparam int COEF_N   = 9;
   localparam int IDX_W    = 4;
   localparam int STEP_W   = 4;

   localparam logic [SCORE_W-1:0] THR_RESET  = 24'd251658;
   localparam logic [SCORE_W-1:0] CEIL_RESET = 24'd392561;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_PAIR  = 2'd2;

   localparam logic [0:0] CSR_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_CEILING   = 1'b1;

   localparam logic [CNT_W-1:0] ND_PT = 4'd3;
   localparam logic [CNT_W-1:0] ND_L  = 4'd10;
   localparam logic [CNT_W-1:0] ND_U  = 4'd13;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_DIV   = 5'b10000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] ndig;
   } mul_ctl_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

endpackage

// File: src/eps_mul.sv
// Digit-serial signed multiplier: one 8-bit digit of the second operand per cycle.
module eps_mul import eps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mul_ctl_type             ctl,
   input  logic signed [A_W-1:0]   a,
   input  logic signed [B_W-1:0]   b,
   output logic signed [ACC_W-1:0] prod,
   output logic                    done
);

   logic signed [A_W-1:0]     a_ff;
   logic        [B_W-1:0]     b_ff, b_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic        [CNT_W-1:0]   cnt_ff;
   logic                      first_ff, done_ff;
   logic        [DIG_W-1:0]   digit;
   logic signed [DIG_W:0]     d9;
   logic signed [A_W+DIG_W:0] pp;

   always_comb begin
      digit = b_ff[B_W-1 -: DIG_W];
      // Horner order from the top digit; only the top digit carries the sign.
      d9 = first_ff ? $signed({digit[DIG_W-1], digit}) : $signed({1'b0, digit});
      pp = a_ff * d9;
      acc_in = (first_ff ? '0 : (acc_ff <<< DIG_W))
               + $signed({{(ACC_W-A_W-DIG_W-1){pp[A_W+DIG_W]}}, pp});
      b_in = b << (DIG_W * (NDIG_MAX - int'(ctl.ndig)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            cnt_ff <= ctl.ndig;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff     <= a;
         b_ff     <= b_in;
         first_ff <= 1'b1;
      end else if (cnt_ff != '0) begin
         acc_ff   <= acc_in;
         b_ff     <= b_ff << DIG_W;
         first_ff <= 1'b0;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

// File: src/eps_div.sv
// Restoring divider for one side value and the threshold test that turns it into a score.
module eps_div import eps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [ACC_W-1:0]   num,
   input  logic [ACC_W-1:0]   den,
   input  logic [SCORE_W-1:0] thr,
   input  logic [SCORE_W-1:0] ceil,
   output logic [SCORE_W-1:0] score,
   output logic               done
);

   logic [ACC_W-1:0]   rem_ff, dsh_ff;
   logic [QUOT_W-1:0]  q_ff;
   logic [DCNT_W-1:0]  cnt_ff;
   logic               zero_ff, big_ff, fin_ff, done_ff;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      if (zero_ff || big_ff || q_ff >= thr || ceil <= q_ff) begin
         score_in = '0;
      end else begin
         score_in = ceil - q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (ctl.start) begin
            cnt_ff <= DCNT_W'(QUOT_W + 1);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1)) begin
               fin_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff  <= num;
         dsh_ff  <= den << QUOT_W;
         q_ff    <= '0;
         zero_ff <= (den == '0);
         big_ff  <= 1'b0;
      end else if (cnt_ff != '0) begin
         // The first step only tells whether the quotient reaches 2^24.
         if (cnt_ff == DCNT_W'(QUOT_W + 1)) begin
            big_ff <= ge;
         end else begin
            q_ff <= {q_ff[QUOT_W-2:0], ge};
         end
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (fin_ff) begin
         score_ff <= score_in;
      end
   end

   assign score = score_ff;
   assign done  = done_ff;

endmodule

// File: src/epipolar_pair_score.sv
// Top level of the epipolar pair scorer: sequencer, matrix store and datapath registers.
//
// Scores point pairs against a stored 3x3 fundamental matrix with the symmetric epipolar
// residual. An item with tuser 0 empties the matrix and clears the running score, tuser 1
// loads one coefficient, both with no result. tuser 2 scores one pair and gives
// one result. Each side runs its line, residual and norm terms through one shared serial
// multiplier that takes one 8-bit digit a cycle, then one 25-step restoring divider; the input
// is not ready while a pair is being scored. A pair against an empty matrix skips the datapath.
// A finished result waits in the output register while the next item is taken.
module epipolar_pair_score import eps_pkg::*; #(
   parameter int POINT_FRAC_BITS = 8,
   parameter int SCORE_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coef_index, coef_value, src_x, src_y, dst_x, dst_y (lowest first), zero filled
   input  logic [151:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // first_side_score, second_side_score, is_inlier, total_score (lowest first), zero filled
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_data
);

   typedef enum logic [1:0] {A_F, A_L0, A_L1, A_U} asel_type;
   typedef enum logic [2:0] {B_PX, B_PY, B_QX, B_QY, B_L0, B_L1, B_U} bsel_type;
   typedef enum logic [2:0] {D_NONE, D_L0, D_L1, D_L2, D_U, D_DEN, D_NUM} dest_type;

   localparam logic [STEP_W-1:0] STEP_LAST = 4'd14;

   state_type            state_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 side_ff, present_ff, rsp_valid_ff, pend_ff;
   logic [TOTAL_W-1:0]   running_ff;
   logic [SCORE_W-1:0]   thr_ff, ceil_ff;

   logic [COEF_W-1:0]    store_ff [COEF_N];
   logic signed [PT_W-1:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic                 last_ff;
   logic signed [ACC_W-1:0] sum_ff, sum_in, base, addend;
   logic signed [L_W-1:0] l0_ff, l1_ff, l2_ff;
   logic signed [U_W-1:0] u_ff;
   logic [ACC_W-1:0]     den_ff, num_in;
   logic [SCORE_W-1:0]   s1_ff, s2_ff;
   logic [SCORE_W-1:0]   out_s1_ff, out_s2_ff;
   logic                 out_inl_ff, out_last_ff;
   logic [TOTAL_W-1:0]   out_total_ff;

   logic                 is_mul, clr;
   asel_type             asel;
   bsel_type             bsel;
   dest_type             dest;
   logic [1:0]           k, t;
   logic [IDX_W-1:0]     fidx;
   logic [CNT_W-1:0]     ndig;
   logic signed [COEF_W-1:0] fval;
   logic signed [PT_W-1:0] px, py, qx, qy;
   logic signed [A_W-1:0] mul_a;
   logic signed [B_W-1:0] mul_b;
   logic signed [ACC_W-1:0] prod;
   logic                 mul_done, div_done;
   logic [SCORE_W-1:0]   div_score;
   mul_ctl_type          mul_ctl;
   div_ctl_type          div_ctl;
   logic                 req_acc, rsp_free, fin;
   logic [TOTAL_W:0]     tot_sum;
   logic [TOTAL_W-1:0]   tot_sat;
   logic [IDX_W-1:0]     ld_idx;

   // Step decode. Steps 0-8 build the three line terms, 9-11 the residual,
   // 12-13 the squared norm and 14 the squared residual.
   always_comb begin
      is_mul = 1'b1;
      clr    = 1'b0;
      asel   = A_F;
      bsel   = B_PX;
      dest   = D_NONE;
      k      = 2'd0;
      t      = 2'd0;
      unique case (step_ff)
         4'd0:  begin k = 2'd0; t = 2'd0; clr = 1'b1; end
         4'd1:  begin k = 2'd0; t = 2'd1; bsel = B_PY; end
         4'd2:  begin k = 2'd0; t = 2'd2; is_mul = 1'b0; dest = D_L0; end
         4'd3:  begin k = 2'd1; t = 2'd0; clr = 1'b1; end
         4'd4:  begin k = 2'd1; t = 2'd1; bsel = B_PY; end
         4'd5:  begin k = 2'd1; t = 2'd2; is_mul = 1'b0; dest = D_L1; end
         4'd6:  begin k = 2'd2; t = 2'd0; clr = 1'b1; end
         4'd7:  begin k = 2'd2; t = 2'd1; bsel = B_PY; end
         4'd8:  begin k = 2'd2; t = 2'd2; is_mul = 1'b0; dest = D_L2; end
         4'd9:  begin asel = A_L0; bsel = B_QX; clr = 1'b1; end
         4'd10: begin asel = A_L1; bsel = B_QY; end
         4'd11: begin is_mul = 1'b0; dest = D_U; end
         4'd12: begin asel = A_L0; bsel = B_L0; clr = 1'b1; end
         4'd13: begin asel = A_L1; bsel = B_L1; dest = D_DEN; end
         4'd14: begin asel = A_U; bsel = B_U; clr = 1'b1; dest = D_NUM; end
         default: begin is_mul = 1'b0; end
      endcase
   end

   always_comb begin
      // First side uses the columns of F against the second point, second side the rows.
      fidx = side_ff ? IDX_W'(3 * int'(k) + int'(t)) : IDX_W'(int'(k) + 3 * int'(t));
      fval = $signed(store_ff[fidx]);
      px = side_ff ? sx_ff : dx_ff;
      py = side_ff ? sy_ff : dy_ff;
      qx = side_ff ? dx_ff : sx_ff;
      qy = side_ff ? dy_ff : sy_ff;
      unique case (asel)
         A_F:     mul_a = A_W'(fval);
         A_L0:    mul_a = A_W'(l0_ff);
         A_L1:    mul_a = A_W'(l1_ff);
         default: mul_a = A_W'(u_ff);
      endcase
      unique case (bsel)
         B_PX:    begin mul_b = B_W'(px);    ndig = ND_PT; end
         B_PY:    begin mul_b = B_W'(py);    ndig = ND_PT; end
         B_QX:    begin mul_b = B_W'(qx);    ndig = ND_PT; end
         B_QY:    begin mul_b = B_W'(qy);    ndig = ND_PT; end
         B_L0:    begin mul_b = B_W'(l0_ff); ndig = ND_L;  end
         B_L1:    begin mul_b = B_W'(l1_ff); ndig = ND_L;  end
         default: begin mul_b = B_W'(u_ff);  ndig = ND_U;  end
      endcase
      base = clr ? '0 : sum_ff;
      if (is_mul) begin
         addend = prod;
      end else if (dest == D_U) begin
         addend = ACC_W'(l2_ff) <<< POINT_FRAC_BITS;
      end else begin
         addend = ACC_W'(fval) <<< POINT_FRAC_BITS;
      end
      sum_in = base + addend;
      num_in = ACC_W'(sum_in) << SCORE_FRAC_BITS;
   end

   assign mul_ctl.start = (state_ff == ST_ISSUE) && is_mul;
   assign mul_ctl.ndig  = ndig;
   assign div_ctl.start = (state_ff == ST_ADD) && (step_ff == STEP_LAST);

   eps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod),
      .done  (mul_done)
   );

   eps_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (num_in),
      .den   (den_ff),
      .thr   (thr_ff),
      .ceil  (ceil_ff),
      .score (div_score),
      .done  (div_done)
   );

   // A finished pair must reach the output register before the next item is taken.
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign ld_idx     = req_tdata[3:0];

   // A pair is finished when the second side is scored or the matrix is empty, and the output is free.
   assign fin = pend_ff && rsp_free;

   always_comb begin
      tot_sum = {1'b0, running_ff} + (TOTAL_W + 1)'(s1_ff) + (TOTAL_W + 1)'(s2_ff);
      tot_sat = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         side_ff      <= 1'b0;
         present_ff   <= 1'b0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         thr_ff       <= THR_RESET;
         ceil_ff      <= CEIL_RESET;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff  <= csr_data;
               CSR_CEILING:   ceil_ff <= csr_data;
               default:       thr_ff  <= thr_ff;
            endcase
         end
         if (fin) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
            running_ff   <= last_ff ? '0 : tot_sat;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  priority if (req_tuser == MODE_CLEAR) begin
                     present_ff <= 1'b0;
                     running_ff <= '0;
                  end else if (req_tuser == MODE_LOAD) begin
                     if (ld_idx < IDX_W'(COEF_N)) begin
                        present_ff <= 1'b1;
                     end
                  end else if (req_tuser == MODE_PAIR) begin
                     if (present_ff) begin
                        state_ff <= ST_ISSUE;
                        step_ff  <= '0;
                        side_ff  <= 1'b0;
                     end else begin
                        pend_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_ISSUE: state_ff <= is_mul ? ST_MUL : ST_ADD;
            ST_MUL: begin
               if (mul_done) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_DIV;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (!side_ff) begin
                     side_ff  <= 1'b1;
                     step_ff  <= '0;
                     state_ff <= ST_ISSUE;
                  end else begin
                     pend_ff  <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (req_tuser == MODE_LOAD && ld_idx < IDX_W'(COEF_N)) begin
            store_ff[ld_idx] <= req_tdata[51:4];
         end
         if (req_tuser == MODE_PAIR) begin
            sx_ff   <= $signed(req_tdata[75:52]);
            sy_ff   <= $signed(req_tdata[99:76]);
            dx_ff   <= $signed(req_tdata[123:100]);
            dy_ff   <= $signed(req_tdata[147:124]);
            last_ff <= req_tlast;
            s1_ff   <= '0;
            s2_ff   <= '0;
         end
      end
      if (state_ff == ST_ADD) begin
         sum_ff <= sum_in;
         unique case (dest)
            D_L0:    l0_ff  <= sum_in[L_W-1:0];
            D_L1:    l1_ff  <= sum_in[L_W-1:0];
            D_L2:    l2_ff  <= sum_in[L_W-1:0];
            D_U:     u_ff   <= sum_in[U_W-1:0];
            D_DEN:   den_ff <= ACC_W'(sum_in) << (2 * POINT_FRAC_BITS);
            default: ;
         endcase
      end
      if (state_ff == ST_DIV && div_done) begin
         if (side_ff) begin
            s2_ff <= div_score;
         end else begin
            s1_ff <= div_score;
         end
      end
      if (fin) begin
         out_s1_ff    <= s1_ff;
         out_s2_ff    <= s2_ff;
         out_inl_ff   <= (s1_ff != '0) && (s2_ff != '0);
         out_total_ff <= tot_sat;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {7'd0, out_total_ff, out_inl_ff, out_s2_ff, out_s1_ff};

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside its wait state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   a_inlier_scores: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[23:0] != 24'd0 && rsp_tdata[47:24] != 24'd0)
      else $error("inlier flag without two positive side scores");

endmodule
